### hdl/bpt_pkg.sv
`timescale 1ns / 1ps

package bpt_pkg;

    // Field widths and bus layout
    localparam int FRAC_BITS_DEF = 24;
    localparam int ADV_W         = 26;
    localparam int COORD_W       = 24;
    localparam int POS_W         = 25;
    localparam int PT_W          = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 80;
    localparam int STEP_W        = 4;

    // Control point reset values: x0..x3 then z0..z3
    localparam logic signed [PT_W-1:0] PT_RESET [NUM_REGS] = '{
        -16'sd5000, -16'sd1000, 16'sd1000, 16'sd5000,
        16'sd20000, -16'sd8000, -16'sd8000, 16'sd20000
    };

    // Multiplier operand A source
    typedef enum logic [2:0] {
        A_NONE = 3'd0,
        A_U    = 3'd1,
        A_T    = 3'd2,
        A_UU   = 3'd3,
        A_TT   = 3'd4,
        A_PT   = 3'd5
    } a_sel_t;

    // Multiplier operand B source
    typedef enum logic [1:0] {
        B_NONE = 2'd0,
        B_U    = 2'd1,
        B_T    = 2'd2,
        B_W    = 2'd3
    } b_sel_t;

    // Destination of the product registered in the previous step
    typedef enum logic [3:0] {
        WB_NONE    = 4'd0,
        WB_U       = 4'd1,
        WB_UU      = 4'd2,
        WB_TT      = 4'd3,
        WB_W0      = 4'd4,
        WB_W1      = 4'd5,
        WB_W2      = 4'd6,
        WB_W3      = 4'd7,
        WB_ACC_LD  = 4'd8,
        WB_ACC_ADD = 4'd9,
        WB_COORD   = 4'd10
    } wb_sel_t;

    // Sequencing: next step, or loop back for the second axis / finish
    typedef enum logic {
        JMP_NEXT = 1'b0,
        JMP_AXIS = 1'b1
    } jmp_t;

    typedef struct packed {
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        logic [1:0]        idx;
        wb_sel_t           wb;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ucode_t;

    localparam logic [STEP_W-1:0] LOOP_START = 4'd8;

    // Microprogram: weights first, then one pass per axis through the
    // control points. Write-back lags the multiply by one step.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{A_NONE, B_NONE, 2'd0, WB_NONE, JMP_AXIS, LOOP_START};
        case (step)
            4'd0:  w = '{A_NONE, B_NONE, 2'd0, WB_U,       JMP_NEXT, LOOP_START};
            4'd1:  w = '{A_U,    B_U,    2'd0, WB_NONE,    JMP_NEXT, LOOP_START};
            4'd2:  w = '{A_T,    B_T,    2'd0, WB_UU,      JMP_NEXT, LOOP_START};
            4'd3:  w = '{A_UU,   B_U,    2'd0, WB_TT,      JMP_NEXT, LOOP_START};
            4'd4:  w = '{A_UU,   B_T,    2'd0, WB_W0,      JMP_NEXT, LOOP_START};
            4'd5:  w = '{A_TT,   B_U,    2'd0, WB_W1,      JMP_NEXT, LOOP_START};
            4'd6:  w = '{A_TT,   B_T,    2'd0, WB_W2,      JMP_NEXT, LOOP_START};
            4'd7:  w = '{A_NONE, B_NONE, 2'd0, WB_W3,      JMP_NEXT, LOOP_START};
            4'd8:  w = '{A_PT,   B_W,    2'd0, WB_NONE,    JMP_NEXT, LOOP_START};
            4'd9:  w = '{A_PT,   B_W,    2'd1, WB_ACC_LD,  JMP_NEXT, LOOP_START};
            4'd10: w = '{A_PT,   B_W,    2'd2, WB_ACC_ADD, JMP_NEXT, LOOP_START};
            4'd11: w = '{A_PT,   B_W,    2'd3, WB_ACC_ADD, JMP_NEXT, LOOP_START};
            4'd12: w = '{A_NONE, B_NONE, 2'd0, WB_ACC_ADD, JMP_NEXT, LOOP_START};
            4'd13: w = '{A_NONE, B_NONE, 2'd0, WB_COORD,   JMP_AXIS, LOOP_START};
            default: w = '{A_NONE, B_NONE, 2'd0, WB_NONE, JMP_AXIS, LOOP_START};
        endcase
        return w;
    endfunction

endpackage

### hdl/bezier_path_tracker.sv
// One item is in flight at a time; a 14-step microprogram drives one shared
// multiplier, with the control-point pass (6 steps) run once per axis.
// A finished result waits in the output register while the next item is taken.
// Reset (aresetn low, synchronous): t cleared to zero, control points to their
// defaults, sequencer idle, no result pending.
`timescale 1ns / 1ps

module bezier_path_tracker #(
    parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // advance[25:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bpt_pkg::S_TDATA_W-1:0]       s_tdata,
    // point_x[23:0], point_z[47:24], position[72:48]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bpt_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpt_pkg::PT_W-1:0]            cfg_data
);
    import bpt_pkg::*;

    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int W_W    = FRAC_BITS + 3;
    localparam int AW     = (FRAC_BITS + 2 > PT_W + 1) ? FRAC_BITS + 2 : PT_W + 1;
    localparam int BW     = FRAC_BITS + 4;
    localparam int PW     = AW + BW;
    localparam int FIX_W  = 2 * FRAC_BITS + 1;
    localparam int SUM_W  = ((ONE_W > ADV_W) ? ONE_W : ADV_W) + 2;
    localparam int ACC_W  = FRAC_BITS + 22;
    localparam int PAD_W  = M_TDATA_W - POS_W - 2 * COORD_W;

    localparam logic [ONE_W-1:0]        ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FIX_W-1:0]        FIX_HALF = FIX_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 9);
    localparam logic signed [ACC_W-1:0] CMAX     = ACC_W'(24'sh7FFFFF);
    localparam logic signed [ACC_W-1:0] CMIN     = ACC_W'(24'sh800000);

    // Control state
    logic                  busy_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  axis_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [ONE_W-1:0]      t_reg;
    logic signed [PT_W-1:0] pts_reg [NUM_REGS];

    // Datapath registers
    logic [ONE_W-1:0]        u_reg, uu_reg, tt_reg;
    logic [W_W-1:0]          w_reg [4];
    logic signed [PW-1:0]    prod_reg;
    logic                    byp_flag_reg;
    logic [ONE_W-1:0]        byp_val_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [COORD_W-1:0]      x_reg;

    ucode_t                  uc;
    logic [ONE_W-1:0]        fa, fb;
    logic signed [PT_W-1:0]  pt;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic                    byp_flag;
    logic [ONE_W-1:0]        byp_val;
    logic [FIX_W-1:0]        fix_sum;
    logic [ONE_W-1:0]        fix_res;
    logic [W_W-1:0]          fix_x3;
    logic signed [ACC_W-1:0] prod_acc;
    logic signed [ACC_W-1:0] rnd;
    logic [COORD_W-1:0]      coord;
    logic signed [SUM_W-1:0] t_sum;
    logic [ONE_W-1:0]        t_wrap;
    logic                    out_free;
    logic                    out_load;

    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign uc = ucode_rom(step_reg);

    // z pass done and the output register can take the beat
    assign out_load = busy_reg && (uc.jmp == JMP_AXIS) && axis_reg && out_free;

    // Parameter update with wrap at both ends
    always_comb begin
        t_sum = SUM_W'($signed({1'b0, t_reg})) + SUM_W'($signed(s_tdata[ADV_W-1:0]));
        if (t_sum > SUM_W'($signed({1'b0, ONE}))) begin
            t_wrap = '0;
        end else if (t_sum[SUM_W-1]) begin
            t_wrap = ONE;
        end else begin
            t_wrap = t_sum[ONE_W-1:0];
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (uc.a_sel)
            A_U:     fa = u_reg;
            A_T:     fa = t_reg;
            A_UU:    fa = uu_reg;
            A_TT:    fa = tt_reg;
            default: fa = '0;
        endcase
        case (uc.b_sel)
            B_U:     fb = u_reg;
            B_T:     fb = t_reg;
            default: fb = '0;
        endcase
        pt = pts_reg[{axis_reg, uc.idx}];
        mul_a = (uc.a_sel == A_PT) ? AW'(pt) : AW'($signed({1'b0, fa}));
        mul_b = (uc.b_sel == B_W) ? BW'($signed({1'b0, w_reg[uc.idx]}))
                                  : BW'($signed({1'b0, fb}));
        // a factor of exactly one passes the other factor through
        byp_flag = 1'b1;
        if (fa == ONE) begin
            byp_val = fb;
        end else if (fb == ONE) begin
            byp_val = fa;
        end else begin
            byp_flag = 1'b0;
            byp_val  = fa;
        end
    end

    // Write-back values from the registered product
    always_comb begin
        fix_sum  = {1'b0, prod_reg[2*FRAC_BITS-1:0]} + FIX_HALF;
        fix_res  = byp_flag_reg ? byp_val_reg : ONE_W'(fix_sum >> FRAC_BITS);
        fix_x3   = W_W'(fix_res) + (W_W'(fix_res) << 1);
        prod_acc = ACC_W'(prod_reg);
        rnd      = (acc_reg + RND_HALF) >>> (FRAC_BITS - 8);
        if (rnd > CMAX) begin
            coord = CMAX[COORD_W-1:0];
        end else if (rnd < CMIN) begin
            coord = CMIN[COORD_W-1:0];
        end else begin
            coord = rnd[COORD_W-1:0];
        end
    end

    // Datapath: multiply and write back under the current control word
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            prod_reg     <= mul_a * mul_b;
            byp_flag_reg <= byp_flag;
            byp_val_reg  <= byp_val;
            case (uc.wb)
                WB_U:       u_reg    <= ONE - t_reg;
                WB_UU:      uu_reg   <= fix_res;
                WB_TT:      tt_reg   <= fix_res;
                WB_W0:      w_reg[0] <= W_W'(fix_res);
                WB_W1:      w_reg[1] <= fix_x3;
                WB_W2:      w_reg[2] <= fix_x3;
                WB_W3:      w_reg[3] <= W_W'(fix_res);
                WB_ACC_LD:  acc_reg  <= prod_acc;
                WB_ACC_ADD: acc_reg  <= acc_reg + prod_acc;
                WB_COORD: begin
                    if (!axis_reg) begin
                        x_reg <= coord;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer, configuration registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            axis_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            t_reg        <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                pts_reg[i] <= PT_RESET[i];
            end
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{PAD_W{1'b0}}, POS_W'(t_reg), coord, x_reg};
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                pts_reg[cfg_index] <= cfg_data;
            end
            if (s_tvalid && !busy_reg) begin
                t_reg    <= t_wrap;
                busy_reg <= 1'b1;
                step_reg <= '0;
                axis_reg <= 1'b0;
            end else if (busy_reg) begin
                case (uc.jmp)
                    JMP_NEXT: step_reg <= step_reg + 1'b1;
                    JMP_AXIS: begin
                        if (!axis_reg) begin
                            axis_reg <= 1'b1;
                            step_reg <= uc.target;
                        end else if (out_free) begin
                            // z finished: result beat goes out, sequencer idles
                            busy_reg <= 1'b0;
                        end
                    end
                    default: step_reg <= step_reg + 1'b1;
                endcase
            end
        end
    end

endmodule

### hdl/bpt_checker.sv
`timescale 1ns / 1ps

module bpt_checker #(
    parameter int FRAC_BITS = bpt_pkg::FRAC_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpt_pkg::M_TDATA_W-1:0] m_tdata
);
    import bpt_pkg::*;

    localparam logic [63:0] ONE_POS = 64'd1 << FRAC_BITS;

    logic [POS_W-1:0] pos;
    assign pos = m_tdata[2*COORD_W +: POS_W];

    // out of reset: idle and nothing pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");

    // one item in flight: input closes after each accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // the curve parameter never leaves 0..1
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (FRAC_BITS > 24) || (64'(pos) <= ONE_POS))
        else $error("position beyond one");

endmodule

bind bezier_path_tracker bpt_checker #(.FRAC_BITS(FRAC_BITS)) u_bpt_checker (.*);

### sim/curve_point_checker.sv
`timescale 1ns / 1ps

module curve_point_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [bpt_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bpt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpt_pkg::PT_W-1:0]          cfg_data,
    input  logic                              end_of_test,
    output int                                outstanding,
    output int                                fail_count,
    output int                                checked,
    output int                                wraps
);

    localparam int     FB     = bpt_pkg::FRAC_BITS_DEF;
    localparam int     CW     = bpt_pkg::COORD_W;
    localparam int     PW     = bpt_pkg::POS_W;
    localparam longint UNIT   = longint'(1) << FB;
    localparam longint SAT_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) << (CW - 1));

    // Laid out as on m_tdata: position on top, point_x in the low bits
    typedef struct packed {
        logic [PW-1:0]        pos;
        logic signed [CW-1:0] pz;
        logic signed [CW-1:0] px;
    } curve_point_t;

    curve_point_t pending_points [$];

    logic [PW-1:0]                    curve_t;
    logic signed [bpt_pkg::PT_W-1:0]  pts [bpt_pkg::NUM_REGS];

    int  errs      = 0;
    int  results   = 0;
    int  wrap_seen = 0;
    bit  closed    = 0;

    assign fail_count = errs;
    assign checked    = results;
    assign wraps      = wrap_seen;

    // Q24 product, rounded half up; a factor of one passes the other through
    function automatic longint fix_mul(input longint a, input longint b);
        if (a == UNIT) return b;
        if (b == UNIT) return a;
        return (a * b + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    // Weighted sum of one axis, rounded to 8 fraction bits and clamped
    function automatic logic signed [CW-1:0] axis_point(input int base,
            input longint w0, input longint w1, input longint w2, input longint w3);
        longint acc;
        longint r;
        acc = longint'(pts[base]) * w0 + longint'(pts[base + 1]) * w1
            + longint'(pts[base + 2]) * w2 + longint'(pts[base + 3]) * w3;
        r = (acc + (longint'(1) << (FB - 9))) >>> (FB - 8);
        if (r > SAT_HI) r = SAT_HI;
        if (r < SAT_LO) r = SAT_LO;
        return r[CW-1:0];
    endfunction

    function automatic curve_point_t expect_point(input longint t);
        longint u, uu, tt, w0, w1, w2, w3;
        curve_point_t p;
        u  = UNIT - t;
        uu = fix_mul(u, u);
        tt = fix_mul(t, t);
        w0 = fix_mul(uu, u);
        w1 = 3 * fix_mul(uu, t);
        w2 = 3 * fix_mul(tt, u);
        w3 = fix_mul(tt, t);
        p.px  = axis_point(0, w0, w1, w2, w3);
        p.pz  = axis_point(4, w0, w1, w2, w3);
        p.pos = t[PW-1:0];
        return p;
    endfunction

    always @(posedge aclk) begin : watch
        curve_point_t got;
        curve_point_t want;
        longint       nt;
        if (!aresetn) begin
            curve_t = '0;
            for (int i = 0; i < bpt_pkg::NUM_REGS; i++) pts[i] = bpt_pkg::PT_RESET[i];
            pending_points.delete();
        end else begin
            // control point writes
            if (cfg_valid && cfg_ready) begin
                pts[cfg_index] = $signed(cfg_data);
            end

            // result beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*CW+PW-1:0];
                if (pending_points.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] result beat with nothing expected: x=%0d z=%0d t=%0d",
                                 $realtime, got.px, got.pz, got.pos);
                end else begin
                    want = pending_points.pop_front();
                    results++;
                    if (got.px !== want.px || got.pz !== want.pz || got.pos !== want.pos) begin
                        errs++;
                        if (errs <= 10)
                            $display("[%0t] mismatch: exp x=%0d z=%0d t=%0d, got x=%0d z=%0d t=%0d",
                                     $realtime, want.px, want.pz, want.pos,
                                     got.px, got.pz, got.pos);
                    end
                end
            end

            // advance beat: step t with wrap, queue the expected point
            if (s_tvalid && s_tready) begin
                nt = longint'(curve_t) + longint'($signed(s_tdata[bpt_pkg::ADV_W-1:0]));
                if (nt > UNIT) begin
                    nt = 0;
                    wrap_seen++;
                end else if (nt < 0) begin
                    nt = UNIT;
                    wrap_seen++;
                end
                curve_t = nt[PW-1:0];
                pending_points.push_back(expect_point(nt));
            end

            if (end_of_test && !closed) begin
                closed = 1;
                if (pending_points.size() != 0) begin
                    errs += pending_points.size();
                    $display("[%0t] %0d expected results never arrived",
                             $realtime, pending_points.size());
                end
            end
        end
        outstanding <= pending_points.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bpt_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X0, REG_X1, REG_X2, REG_X3,
        REG_Z0, REG_Z1, REG_Z2, REG_Z3
    } point_reg_t;

    localparam int ONE_T       = 1 << FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [PT_W-1:0]        cfg_data    = '0;
    logic                   end_of_test = 1'b0;

    int outstanding;
    int fail_count;
    int checked;
    int wraps;

    bit  gaps_on    = 1'b1;
    int  beats_sent = 0;
    int  settings   = 1;
    int  cycle_count = 0;

    logic signed [PT_W-1:0] next_pts [NUM_REGS];

    always #6 aclk = ~aclk;

    bezier_path_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    curve_point_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .end_of_test (end_of_test),
        .outstanding (outstanding),
        .fail_count  (fail_count),
        .checked     (checked),
        .wraps       (wraps)
    );

    // One advance beat; valid stays up when no gap is drawn
    task automatic offer_advance(input int adv);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-ADV_W){1'b0}}, adv[ADV_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // Drop valid and wait for every expected point to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Write all eight control points back to back
    task automatic load_points();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= point_reg_t'(i);
            cfg_data  <= next_pts[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic int random_advance();
        int pick;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 50)      mag = $urandom_range(0, 1 << 18);
        else if (pick < 75) mag = $urandom_range(0, ONE_T);
        else if (pick < 85) mag = ONE_T;
        else if (pick < 92) mag = $urandom_range(0, 1);
        else return $urandom_range(0, 2 * ONE_T) - ONE_T;
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Runs of steady motion (fixed speed and direction), with odd jumps mixed in
    task automatic random_run(input int count);
        int  left;
        int  speed;
        bit  back;
        left  = 0;
        speed = 0;
        back  = 1'b0;
        repeat (count) begin
            if (left == 0) begin
                left  = $urandom_range(1, 40);
                speed = $urandom_range(0, 3) == 0 ? $urandom_range(0, ONE_T)
                                                  : $urandom_range(0, 1 << 20);
                back  = $urandom_range(0, 1);
            end
            left--;
            if ($urandom_range(0, 9) < 7) offer_advance(back ? -speed : speed);
            else offer_advance(random_advance());
        end
    endtask

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin : result_sink
        int stall;
        int beats;
        bit held;
        beats = 0;
        held  = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && beats == 300) begin
                held  = 1'b1;
                stall = 500;
            end else begin
                stall = gaps_on ? $urandom_range(0, 4) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats++;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk at the default points, t starting from zero
        offer_advance(0);                 // stay at zero
        offer_advance(ONE_T);             // land exactly on one
        offer_advance(0);                 // one is kept
        offer_advance(1);                 // wrap high to zero
        offer_advance(-1);                // wrap low to one
        offer_advance(-ONE_T);            // back to zero
        offer_advance(-ONE_T);            // wrap low from zero
        offer_advance(ONE_T);             // wrap high from one
        offer_advance(ONE_T / 2);         // midpoint
        offer_advance(ONE_T / 2);         // up to one again
        offer_advance(-(ONE_T / 2) - 1);
        offer_advance(32'h00AA_AAAA - ONE_T);
        offer_advance(32'h0055_5555);
        offer_advance(-ONE_T);

        // all points at the negative extreme
        settle();
        for (int i = 0; i < NUM_REGS; i++) next_pts[i] = 16'sh8000;
        load_points();
        offer_advance(-ONE_T);
        offer_advance(ONE_T / 3);
        offer_advance(ONE_T / 3);
        offer_advance(ONE_T / 3);
        offer_advance(ONE_T);

        // all points at the positive extreme
        settle();
        for (int i = 0; i < NUM_REGS; i++) next_pts[i] = 16'sh7FFF;
        load_points();
        offer_advance(-ONE_T);
        offer_advance(ONE_T / 2);
        offer_advance(-(ONE_T / 4));
        offer_advance(ONE_T);
        offer_advance(1);

        // random phases, each under a fresh set of control points
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            for (int i = 0; i < NUM_REGS; i++) begin
                if (ph == 0)
                    next_pts[i] = i[0] ? 16'sh7FFF : 16'sh8000;
                else if ($urandom_range(0, 2) == 0)
                    next_pts[i] = $urandom_range(0, 400) - 200;
                else
                    next_pts[i] = $urandom_range(0, 65535);
            end
            load_points();
            repeat (5) begin
                gaps_on = $urandom_range(0, 3) != 0;
                random_run(50);
            end
        end

        // back to the reset curve for a last stretch
        settle();
        next_pts[REG_X0] = -16'sd5000;
        next_pts[REG_X1] = -16'sd1000;
        next_pts[REG_X2] = 16'sd1000;
        next_pts[REG_X3] = 16'sd5000;
        next_pts[REG_Z0] = 16'sd20000;
        next_pts[REG_Z1] = -16'sd8000;
        next_pts[REG_Z2] = -16'sd8000;
        next_pts[REG_Z3] = 16'sd20000;
        load_points();
        gaps_on = 1'b1;
        random_run(50);

        settle();
        repeat (30) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);

        $display("Sent %0d advance beats under %0d control point sets; %0d points compared.",
                 beats_sent, settings, checked);
        $display("The curve parameter wrapped past zero or one %0d times.",
                 wraps);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
